/* rtl/chacha_pkg.sv */
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR package
// Shared types, constants and helper functions for the ChaCha20 byte cipher.
// ----------------------------------------------------------------------------
package chacha_pkg;

  // Block function constants ("expand 32-byte k").
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int DOUBLE_ROUNDS = 10;
  // Each double round is two half rounds of four dependent add/xor/rotate steps.
  localparam int NUM_STEPS = DOUBLE_ROUNDS * 8;
  localparam int STEP_W = $clog2(NUM_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_STEPS - 1);

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_NONCE_L = 3'd4;
  localparam logic [2:0] REG_NONCE_H = 3'd5;
  localparam logic [2:0] REG_CTR     = 3'd6;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       accept;     // latch the incoming word
    logic       init;       // load the working state for a new block
    logic       msg_start;  // the new block uses the first counter
    logic       step;       // run one add/xor/rotate step on all four lanes
    logic [1:0] phase;      // which of the four quarter-round steps
    logic       diag;       // diagonal half round when set
    logic       finalize;   // add the initial state, store the keystream
    logic       emit;       // load the output register
    logic [5:0] pos;        // keystream byte position
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic last;      // latched last flag of the current word
    logic out_free;  // output register can take a word this cycle
  } dp_sts_t;

  // Working-state index for a lane and a role (a, b, c, d) of a quarter round.
  function automatic logic [3:0] qr_idx(logic [1:0] lane, logic [1:0] role, logic diag);
    logic [1:0] col;
    col = diag ? (lane + role) : lane;
    return {role, col};
  endfunction

  // Rotation used by each quarter-round step.
  function automatic logic [31:0] qr_rot(logic [31:0] v, logic [1:0] phase);
    logic [31:0] r;
    case (phase)
      2'd0: r = {v[15:0], v[31:16]};
      2'd1: r = {v[19:0], v[31:20]};
      2'd2: r = {v[23:0], v[31:24]};
      2'd3: r = {v[24:0], v[31:25]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

/* rtl/chacha20_stream_xor_unit.sv */
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR unit
// A word inside a 64-byte block is latched on accept and then emitted; a word
// that starts a block first waits for the block function (80 quarter-round
// steps, one per cycle, in the shared four-lane step unit, then finalize).
// A new word is taken only once the last is emitted; out_stall holds the emit.
// Reset (synchronous, rst_n low) clears config, counters, state and out_valid.
// ----------------------------------------------------------------------------
module chacha20_stream_xor_unit
  import chacha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  chacha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Block function and output datapath.
  chacha_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

/* rtl/chacha_dp.sv */
// ----------------------------------------------------------------------------
// ChaCha20 datapath
// Configuration registers, block counter, working state with a four-lane
// quarter-round step unit, keystream block register and output register.
// ----------------------------------------------------------------------------
module chacha_dp
  import chacha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts
);

  logic [63:0] key_r [4];
  logic [63:0] nonce_lo_r;
  logic [31:0] nonce_hi_r;
  logic [31:0] first_ctr_r;
  logic [31:0] blk_ctr_r;
  logic [31:0] ctr_word_r;

  logic [31:0] work_r [16];
  logic [31:0] work_nxt [16];
  logic [511:0] ks_r;

  logic [7:0] byte_r;
  logic       last_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic [31:0] ctr_use;
  logic [31:0] ctr_src;
  logic [31:0] init_w [16];

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      first_ctr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0:    key_r[0] <= cfg_wdata;
        REG_KEY1:    key_r[1] <= cfg_wdata;
        REG_KEY2:    key_r[2] <= cfg_wdata;
        REG_KEY3:    key_r[3] <= cfg_wdata;
        REG_NONCE_L: nonce_lo_r <= cfg_wdata;
        REG_NONCE_H: nonce_hi_r <= cfg_wdata[31:0];
        REG_CTR:     first_ctr_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Counter for the block being started; the first block reloads it.
  assign ctr_use = cmd.msg_start ? first_ctr_r : blk_ctr_r;
  assign ctr_src = cmd.init ? ctr_use : ctr_word_r;

  // Initial block state from constants, key, counter and nonce.
  always_comb begin
    init_w[0] = SIGMA0;
    init_w[1] = SIGMA1;
    init_w[2] = SIGMA2;
    init_w[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = key_r[i][31:0];
      init_w[5 + 2 * i] = key_r[i][63:32];
    end
    init_w[12] = ctr_src;
    init_w[13] = nonce_lo_r[31:0];
    init_w[14] = nonce_lo_r[63:32];
    init_w[15] = nonce_hi_r;
  end

  // Block counter advances once per generated block, wrapping at 2^32.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_ctr_r  <= '0;
      ctr_word_r <= '0;
    end else if (cmd.init) begin
      blk_ctr_r  <= ctr_use + 32'd1;
      ctr_word_r <= ctr_use;
    end
  end

  // One quarter-round step on all four lanes: x += y; z = rot(z ^ x).
  always_comb begin
    logic [1:0]  rx, ry, rz;
    logic [3:0]  ix, iy, iz;
    logic [31:0] sum;
    rx = cmd.phase[0] ? 2'd2 : 2'd0;
    ry = cmd.phase[0] ? 2'd3 : 2'd1;
    rz = cmd.phase[0] ? 2'd1 : 2'd3;
    for (int w = 0; w < 16; w++) work_nxt[w] = work_r[w];
    for (int l = 0; l < 4; l++) begin
      ix  = qr_idx(2'(l), rx, cmd.diag);
      iy  = qr_idx(2'(l), ry, cmd.diag);
      iz  = qr_idx(2'(l), rz, cmd.diag);
      sum = work_r[ix] + work_r[iy];
      work_nxt[ix] = sum;
      work_nxt[iz] = qr_rot(work_r[iz] ^ sum, cmd.phase);
    end
  end

  // Working state and keystream block.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int w = 0; w < 16; w++) work_r[w] <= init_w[w];
    end else if (cmd.step) begin
      for (int w = 0; w < 16; w++) work_r[w] <= work_nxt[w];
    end
    if (cmd.finalize) begin
      for (int w = 0; w < 16; w++) ks_r[32 * w +: 32] <= work_r[w] + init_w[w];
    end
  end

  // Latched input word.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= byte_r ^ ks_r[{cmd.pos, 3'b000} +: 8];
      out_last_r <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_last     = out_last_r;
  assign sts.last     = last_r;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

/* rtl/chacha_ctrl.sv */
// ----------------------------------------------------------------------------
// ChaCha20 controller
// Sequences word intake, block generation, finalization and output, and
// tracks the byte position and message boundaries.
// ----------------------------------------------------------------------------
module chacha_ctrl
  import chacha_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [5:0]        pos_r, pos_nxt;
  logic              mid_r, mid_nxt;

  // Next-state and command logic.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    pos_nxt   = pos_r;
    mid_nxt   = mid_r;
    in_stall  = 1'b1;
    cmd       = '0;
    cmd.phase = step_r[1:0];
    cmd.diag  = step_r[2];
    cmd.pos   = pos_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          mid_nxt    = 1'b1;
          // A new block is needed at every 64-byte boundary.
          if (pos_r == 6'd0) begin
            cmd.init      = 1'b1;
            cmd.msg_start = !mid_r;
            step_nxt      = '0;
            state_nxt     = ST_ROUND;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_ROUND: begin
        cmd.step = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd.finalize = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
          // The last word ends the message and rewinds the position.
          if (sts.last) begin
            pos_nxt = '0;
            mid_nxt = 1'b0;
          end else begin
            pos_nxt = pos_r + 6'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      pos_r   <= '0;
      mid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pos_r   <= pos_nxt;
      mid_r   <= mid_nxt;
    end
  end

endmodule
